### hdl/fwsl_pkg.sv
// Shared types, command codes and decode function for the four-wheel steer limit sequencer.
package fwsl_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_IDX_W       = 8;
    localparam int CFG_DATA_W      = 8;
    localparam int NUM_WHEELS      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_DRIVE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SPOT_DRIVE   = CFG_IDX_W'(1);

    localparam logic [CFG_DATA_W-1:0] MANUAL_DRIVE_RST = CFG_DATA_W'(150);
    localparam logic [CFG_DATA_W-1:0] SPOT_DRIVE_RST   = CFG_DATA_W'(100);

    localparam logic signed [15:0] CMD_ZERO      = 16'sd0;
    localparam logic signed [15:0] CMD_FL_NEG    = 16'sd1;
    localparam logic signed [15:0] CMD_FL_POS    = 16'sd2;
    localparam logic signed [15:0] CMD_FR_POS    = 16'sd3;
    localparam logic signed [15:0] CMD_FR_NEG    = 16'sd4;
    localparam logic signed [15:0] CMD_BL_POS    = 16'sd5;
    localparam logic signed [15:0] CMD_BL_NEG    = 16'sd6;
    localparam logic signed [15:0] CMD_STRAIGHT  = 16'sd7;
    localparam logic signed [15:0] CMD_SPOT_TURN = 16'sd8;
    localparam logic signed [15:0] CMD_FRONT_NEG = 16'sd25;
    localparam logic signed [15:0] CMD_FRONT_POS = 16'sd50;

    localparam logic [1:0] STATUS_IDLE        = 2'd0;
    localparam logic [1:0] STATUS_SPOT_RUN    = 2'd1;
    localparam logic [1:0] STATUS_SPOT_DONE   = 2'd2;
    localparam logic [1:0] STATUS_STRAIGHTING = 2'd3;

    typedef logic signed [8:0] t_drive;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_ZERO_ALL,
        OP_MANUAL,
        OP_SPOT,
        OP_STRAIGHT,
        OP_INVALID
    } t_op;

    typedef struct packed {
        t_op                    op;
        logic [NUM_WHEELS-1:0]  wheel_mask;
        logic                   neg;
        logic [NUM_WHEELS-1:0]  straight_limits;
        logic [NUM_WHEELS-1:0]  turn_limits;
    } t_item;

    function automatic t_item decode(input logic func, input logic signed [15:0] command,
                                     input logic [3:0] straight_limits,
                                     input logic [3:0] turn_limits);
        t_item item;
        item.op              = OP_TICK;
        item.wheel_mask      = '0;
        item.neg             = 1'b0;
        item.straight_limits = straight_limits;
        item.turn_limits     = turn_limits;
        if (!func) begin
            unique case (command)
                CMD_ZERO:      item.op = OP_ZERO_ALL;
                CMD_FL_NEG:    begin item.op = OP_MANUAL; item.wheel_mask = 4'b0001;
                                     item.neg = 1'b1; end
                CMD_FL_POS:    begin item.op = OP_MANUAL; item.wheel_mask = 4'b0001; end
                CMD_FR_POS:    begin item.op = OP_MANUAL; item.wheel_mask = 4'b0010; end
                CMD_FR_NEG:    begin item.op = OP_MANUAL; item.wheel_mask = 4'b0010;
                                     item.neg = 1'b1; end
                CMD_BL_POS:    begin item.op = OP_MANUAL; item.wheel_mask = 4'b0100; end
                CMD_BL_NEG:    begin item.op = OP_MANUAL; item.wheel_mask = 4'b0100;
                                     item.neg = 1'b1; end
                CMD_FRONT_POS: begin item.op = OP_MANUAL; item.wheel_mask = 4'b0011; end
                CMD_FRONT_NEG: begin item.op = OP_MANUAL; item.wheel_mask = 4'b0011;
                                     item.neg = 1'b1; end
                CMD_SPOT_TURN: item.op = OP_SPOT;
                CMD_STRAIGHT:  item.op = OP_STRAIGHT;
                default:       item.op = OP_INVALID;
            endcase
        end
        return item;
    endfunction

endpackage

### hdl/four_wheel_steer_limit_sequencer_core.sv
// Top level of the four-wheel steer limit sequencer: config registers, front, queue, back.
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+------------------------------------
//  input    | in        | i_valid / o_stall             | func, command, straight/turn limits
//  result   | out       | o_valid / i_stall             | four drives, status, three flags
//  config   | in        | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while i_stall stays low; each item is written to a queue entry
// and then to the back-end result register before it appears on the result channel.
// Synchronous active-low reset clears queue, mode, status and drives; config returns to 150/100.
// o_stall rises only when the queue is full; the queue absorbs output stalls.
module four_wheel_steer_limit_sequencer_core #(
    parameter int QUEUE_DEPTH = fwsl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_func,
    input  logic signed [15:0]                i_command,
    input  logic [3:0]                        i_straight_limits,
    input  logic [3:0]                        i_turn_limits,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [8:0]                 o_drive_front_left,
    output logic signed [8:0]                 o_drive_front_right,
    output logic signed [8:0]                 o_drive_back_left,
    output logic signed [8:0]                 o_drive_back_right,
    output logic [1:0]                        o_status_code,
    output logic                              o_mode_complete,
    output logic                              o_invalid_command,
    output logic                              o_busy_reject,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fwsl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fwsl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [fwsl_pkg::CFG_DATA_W-1:0] r_manual_drive;
    logic [fwsl_pkg::CFG_DATA_W-1:0] r_spot_drive;
    logic                            queue_full;
    logic                            push;
    logic                            pop;
    logic                            queue_valid;
    fwsl_pkg::t_item                 front_item;
    fwsl_pkg::t_item                 queue_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manual_drive <= fwsl_pkg::MANUAL_DRIVE_RST;
            r_spot_drive   <= fwsl_pkg::SPOT_DRIVE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                fwsl_pkg::CFG_MANUAL_DRIVE: r_manual_drive <= i_cfg_data;
                fwsl_pkg::CFG_SPOT_DRIVE:   r_spot_drive   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    fwsl_front u_front (
        .i_valid           (i_valid),
        .i_queue_full      (queue_full),
        .i_func            (i_func),
        .i_command         (i_command),
        .i_straight_limits (i_straight_limits),
        .i_turn_limits     (i_turn_limits),
        .o_stall           (o_stall),
        .o_push            (push),
        .o_item            (front_item)
    );

    fwsl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_data  (queue_item)
    );

    fwsl_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_item_valid        (queue_valid),
        .i_item              (queue_item),
        .o_pop               (pop),
        .i_manual_drive      (r_manual_drive),
        .i_spot_drive        (r_spot_drive),
        .i_stall             (i_stall),
        .o_valid             (o_valid),
        .o_drive_front_left  (o_drive_front_left),
        .o_drive_front_right (o_drive_front_right),
        .o_drive_back_left   (o_drive_back_left),
        .o_drive_back_right  (o_drive_back_right),
        .o_status_code       (o_status_code),
        .o_mode_complete     (o_mode_complete),
        .o_invalid_command   (o_invalid_command),
        .o_busy_reject       (o_busy_reject)
    );

endmodule

### hdl/fwsl_front.sv
// Front end: accepts input items and classifies them into queue entries.
module fwsl_front (
    input  logic                i_valid,
    input  logic                i_queue_full,
    input  logic                i_func,
    input  logic signed [15:0]  i_command,
    input  logic [3:0]          i_straight_limits,
    input  logic [3:0]          i_turn_limits,
    output logic                o_stall,
    output logic                o_push,
    output fwsl_pkg::t_item     o_item
);

    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;
    assign o_item  = fwsl_pkg::decode(i_func, i_command, i_straight_limits, i_turn_limits);

endmodule

### hdl/fwsl_queue.sv
// Short queue of classified items between front and back end.
module fwsl_queue #(
    parameter int DEPTH = fwsl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fwsl_pkg::t_item i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output fwsl_pkg::t_item o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fwsl_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hdl/fwsl_back.sv
// Back end: applies queued items to drive and mode state and holds the result register.
module fwsl_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_item_valid,
    input  fwsl_pkg::t_item       i_item,
    output logic                  o_pop,
    input  logic [7:0]            i_manual_drive,
    input  logic [7:0]            i_spot_drive,
    input  logic                  i_stall,
    output logic                  o_valid,
    output fwsl_pkg::t_drive      o_drive_front_left,
    output fwsl_pkg::t_drive      o_drive_front_right,
    output fwsl_pkg::t_drive      o_drive_back_left,
    output fwsl_pkg::t_drive      o_drive_back_right,
    output logic [1:0]            o_status_code,
    output logic                  o_mode_complete,
    output logic                  o_invalid_command,
    output logic                  o_busy_reject
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_SPOT,
        MODE_STRAIGHT
    } t_mode;

    t_mode             r_mode, n_mode;
    fwsl_pkg::t_drive  r_drive [fwsl_pkg::NUM_WHEELS];
    fwsl_pkg::t_drive  n_drive [fwsl_pkg::NUM_WHEELS];
    logic [1:0]        r_status, n_status;
    logic              r_out_valid;
    fwsl_pkg::t_drive  r_res_drive [fwsl_pkg::NUM_WHEELS];
    logic [1:0]        r_res_status;
    logic              r_res_complete, n_complete;
    logic              r_res_invalid, n_invalid;
    logic              r_res_busy, n_busy;
    fwsl_pkg::t_drive  man_pos, man_neg, spot_pos, spot_neg;
    logic [3:0]        lim;

    assign o_pop    = i_item_valid && (!r_out_valid || !i_stall);
    assign man_pos  = fwsl_pkg::t_drive'({1'b0, i_manual_drive});
    assign man_neg  = -man_pos;
    assign spot_pos = fwsl_pkg::t_drive'({1'b0, i_spot_drive});
    assign spot_neg = -spot_pos;

    always_comb begin
        n_mode     = r_mode;
        n_drive    = r_drive;
        n_status   = r_status;
        n_complete = 1'b0;
        n_invalid  = 1'b0;
        n_busy     = 1'b0;
        lim        = '0;
        if (i_item.op != fwsl_pkg::OP_TICK) begin
            if (r_mode != MODE_IDLE) begin
                n_busy = 1'b1;
            end else begin
                unique case (i_item.op)
                    fwsl_pkg::OP_TICK: begin
                    end
                    fwsl_pkg::OP_ZERO_ALL: begin
                        for (int i = 0; i < fwsl_pkg::NUM_WHEELS; i++) n_drive[i] = '0;
                    end
                    fwsl_pkg::OP_MANUAL: begin
                        for (int i = 0; i < fwsl_pkg::NUM_WHEELS; i++) begin
                            if (i_item.wheel_mask[i]) n_drive[i] = i_item.neg ? man_neg : man_pos;
                        end
                    end
                    fwsl_pkg::OP_SPOT: begin
                        n_mode   = MODE_SPOT;
                        n_status = fwsl_pkg::STATUS_SPOT_RUN;
                    end
                    fwsl_pkg::OP_STRAIGHT: begin
                        n_mode   = MODE_STRAIGHT;
                        n_status = fwsl_pkg::STATUS_STRAIGHTING;
                    end
                    fwsl_pkg::OP_INVALID: begin
                        for (int i = 0; i < fwsl_pkg::NUM_WHEELS; i++) n_drive[i] = '0;
                        n_invalid = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (n_mode != MODE_IDLE) begin
            lim = (n_mode == MODE_SPOT) ? i_item.turn_limits : i_item.straight_limits;
            for (int i = 0; i < fwsl_pkg::NUM_WHEELS; i++) begin
                if (!lim[i]) begin
                    n_drive[i] = '0;
                end else if ((i % 2 == 1) != (n_mode == MODE_STRAIGHT)) begin
                    n_drive[i] = spot_neg;
                end else begin
                    n_drive[i] = spot_pos;
                end
            end
            if (lim == '0) begin
                n_status   = (n_mode == MODE_SPOT) ? fwsl_pkg::STATUS_SPOT_DONE
                                                   : fwsl_pkg::STATUS_IDLE;
                n_mode     = MODE_IDLE;
                n_complete = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_status    <= fwsl_pkg::STATUS_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < fwsl_pkg::NUM_WHEELS; i++) r_drive[i] <= '0;
        end else begin
            if (o_pop) begin
                r_mode         <= n_mode;
                r_status       <= n_status;
                r_drive        <= n_drive;
                r_res_drive    <= n_drive;
                r_res_status   <= n_status;
                r_res_complete <= n_complete;
                r_res_invalid  <= n_invalid;
                r_res_busy     <= n_busy;
                r_out_valid    <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    assign o_valid             = r_out_valid;
    assign o_drive_front_left  = r_res_drive[0];
    assign o_drive_front_right = r_res_drive[1];
    assign o_drive_back_left   = r_res_drive[2];
    assign o_drive_back_right  = r_res_drive[3];
    assign o_status_code       = r_res_status;
    assign o_mode_complete     = r_res_complete;
    assign o_invalid_command   = r_res_invalid;
    assign o_busy_reject       = r_res_busy;

    a_complete_ends_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res_complete |-> r_mode == MODE_IDLE)
        else $error("mode still running after completion");

    a_invalid_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res_invalid |->
            r_res_drive[0] == '0 && r_res_drive[1] == '0 &&
            r_res_drive[2] == '0 && r_res_drive[3] == '0 && !r_res_busy)
        else $error("invalid command left drives set");

    a_spot_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_SPOT |-> r_status == fwsl_pkg::STATUS_SPOT_RUN)
        else $error("spot turn running with wrong status");

    a_straight_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_STRAIGHT |-> r_status == fwsl_pkg::STATUS_STRAIGHTING)
        else $error("straighten running with wrong status");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |=> r_out_valid && $stable(r_res_status))
        else $error("stalled result lost");

endmodule
